@@ rtl/plws_pkg.sv @@
`default_nettype none

package plws_pkg;

   // default sizes of the top-level parameters
   localparam int SAMPLES_PER_AVERAGE_DEF = 20;
   localparam int BREAKPOINTS_DEF         = 11;
   localparam int ADC_BITS_DEF            = 10;

   // fixed field widths
   localparam int SAMPLE_W = 10;
   localparam int INDEX_W  = 4;
   localparam int SUM_W    = 15;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 5;

   // (sum - lo) * 1000 stays below 2^25
   localparam int NUM_W = 25;

   localparam int GRAMS_PER_POINT = 1000;

   localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   // register file: byte address 4*i, index in paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_MODE_INDEX = 1'b0;

endpackage : plws_pkg

`default_nettype wire

@@ rtl/piecewise_linear_weight_scale.sv @@
`default_nettype none

// Channel  Direction  Handshake               Beat contents
// req      in         req_valid / req_ready   func, adc_sample, point_index, point_value
// rsp      out        rsp_valid / rsp_ready   weight_grams, sample_sum, is_calibration,
//                                             stored_slot, fault
// csr      in/out     psel, penable, pwrite   calibrate_mode at byte address 0
//
// A point write or a non-closing sample completes when it is accepted. A closing sample
// in calibrate mode is written to the table and goes to the finish state. In measure
// mode it passes through accept, a read and a check per breakpoint (1 to BREAKPOINTS),
// scale, divide (25 quotient bits, then done) and finish; a sum at or below point 0
// goes from the check of point 0 to finish, and a faulting last segment from scale.
// Reset clears the breakpoint valid bits; a closing sample holds in the finish state
// while a result waits in the output register.
module piecewise_linear_weight_scale #(
   parameter int SAMPLES_PER_AVERAGE = plws_pkg::SAMPLES_PER_AVERAGE_DEF,
   parameter int BREAKPOINTS         = plws_pkg::BREAKPOINTS_DEF,
   parameter int ADC_BITS            = plws_pkg::ADC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_func,
   input  wire logic [plws_pkg::SAMPLE_W-1:0]       req_adc_sample,
   input  wire logic [plws_pkg::INDEX_W-1:0]        req_point_index,
   input  wire logic [plws_pkg::SUM_W-1:0]          req_point_value,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [plws_pkg::WEIGHT_W-1:0]       rsp_weight_grams,
   output logic      [plws_pkg::SUM_W-1:0]          rsp_sample_sum,
   output logic                                     rsp_is_calibration,
   output logic      [plws_pkg::INDEX_W-1:0]        rsp_stored_slot,
   output logic                                     rsp_fault,

   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [plws_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [plws_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [plws_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   localparam int ADDR_W   = $clog2(BREAKPOINTS);
   localparam int SAMPLE_W = plws_pkg::SAMPLE_W;
   localparam int INDEX_W  = plws_pkg::INDEX_W;
   localparam int SUM_W    = plws_pkg::SUM_W;
   localparam int WEIGHT_W = plws_pkg::WEIGHT_W;
   localparam int COUNT_W  = plws_pkg::COUNT_W;
   localparam int NUM_W    = plws_pkg::NUM_W;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
      (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(BREAKPOINTS - 1);
   localparam logic [INDEX_W-1:0] LAST_SLOT = INDEX_W'(BREAKPOINTS - 1);
   localparam logic [INDEX_W:0]   POINT_LIMIT = (INDEX_W + 1)'(BREAKPOINTS);
   localparam logic [COUNT_W:0]   GROUP_LEN = (COUNT_W + 1)'(SAMPLES_PER_AVERAGE);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_SCALE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [INDEX_W-1:0]   slot_ff, slot_in;

   // working registers of the group in flight
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]     prev_ff, prev_in;
   logic [SUM_W-1:0]     lo_ff, lo_in;
   logic [SUM_W-1:0]     hi_ff, hi_in;
   logic [ADDR_W-1:0]    seg_ff, seg_in;
   logic [WEIGHT_W-1:0]  base_ff, base_in;
   logic [WEIGHT_W-1:0]  grams_ff, grams_in;
   logic                 fault_ff, fault_in;
   logic                 iscal_ff, iscal_in;
   logic [INDEX_W-1:0]   slotout_ff, slotout_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0]  rsp_grams_ff, rsp_grams_in;
   logic [SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic                 rsp_iscal_ff, rsp_iscal_in;
   logic [INDEX_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                 rsp_fault_ff, rsp_fault_in;

   // memory and divider hookup
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [SUM_W-1:0]     mem_wr_data;
   logic                 mem_rd_en;
   logic [SUM_W-1:0]     mem_rd_data;
   logic                 div_start;
   logic [NUM_W-1:0]     div_dividend;
   logic [SUM_W-1:0]     div_divisor;
   logic                 div_done;
   logic [NUM_W-1:0]     div_quotient;

   logic                 csr_wr;
   logic [SAMPLE_W-1:0]  sample_masked;
   logic [SUM_W:0]       acc_sum;
   logic [SUM_W-1:0]     acc_sat;
   logic [COUNT_W:0]     count_next;
   logic                 degenerate;
   logic [ADDR_W-1:0]    seg_m1;
   logic [NUM_W:0]       grams_total;

   plws_bp_mem #(
      .DEPTH  (BREAKPOINTS),
      .ADDR_W (ADDR_W),
      .DATA_W (SUM_W)
   ) u_bp_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mem_rd_data)
   );

   plws_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // register port: write completes in the access cycle
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == plws_pkg::CSR_MODE_INDEX) ?
                       {{(plws_pkg::CSR_DATA_W-1){1'b0}}, mode_ff} : '0;

   assign req_ready = (state_ff == S_IDLE);

   // running sum and segment arithmetic
   assign sample_masked = req_adc_sample & SAMPLE_MASK;
   assign acc_sum       = {1'b0, acc_ff} + {{(SUM_W+1-SAMPLE_W){1'b0}}, sample_masked};
   assign acc_sat       = acc_sum[SUM_W] ? plws_pkg::SUM_MAX : acc_sum[SUM_W-1:0];
   assign count_next    = {1'b0, count_ff} + 1'b1;
   assign degenerate    = (hi_ff <= lo_ff) || (sum_ff <= lo_ff);
   assign seg_m1        = seg_ff - 1'b1;
   assign div_dividend  = NUM_W'(NUM_W'(sum_ff - lo_ff) * NUM_W'(plws_pkg::GRAMS_PER_POINT));
   assign div_divisor   = hi_ff - lo_ff;
   assign div_start     = (state_ff == S_SCALE) && !degenerate;
   assign mem_rd_en     = (state_ff == S_READ);
   assign grams_total   = {{(NUM_W+1-WEIGHT_W){1'b0}}, base_ff} + {1'b0, div_quotient};

   // sequencer: accept, store or search the table, divide, deliver
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      seg_in       = seg_ff;
      base_in      = base_ff;
      grams_in     = grams_ff;
      fault_in     = fault_ff;
      iscal_in     = iscal_ff;
      slotout_in   = slotout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_grams_in = rsp_grams_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_iscal_in = rsp_iscal_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fault_in = rsp_fault_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ADDR_W'(req_point_index);
      mem_wr_data  = req_point_value;

      if (csr_wr && (csr_paddr[2] == plws_pkg::CSR_MODE_INDEX)) begin
         mode_in = csr_pwdata[0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func) begin
                  // direct point write; out-of-range index is dropped
                  mem_wr_en = ({1'b0, req_point_index} < POINT_LIMIT);
               end else if (count_next >= GROUP_LEN) begin
                  sum_in   = acc_sat;
                  acc_in   = '0;
                  count_in = '0;
                  if (mode_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = ADDR_W'(slot_ff);
                     mem_wr_data = acc_sat;
                     iscal_in    = 1'b1;
                     slotout_in  = slot_ff;
                     grams_in    = '0;
                     fault_in    = 1'b0;
                     slot_in     = (slot_ff >= LAST_SLOT) ? '0 : slot_ff + 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     iscal_in   = 1'b0;
                     slotout_in = '0;
                     idx_in     = '0;
                     state_in   = S_READ;
                  end
               end else begin
                  acc_in   = acc_sat;
                  count_in = count_next[COUNT_W-1:0];
               end
            end
         end

         S_READ: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (idx_ff == '0) begin
               if (sum_ff <= mem_rd_data) begin
                  grams_in = '0;
                  fault_in = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  prev_in  = mem_rd_data;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end else if ((sum_ff <= mem_rd_data) || (idx_ff == LAST_ADDR)) begin
               // first point at or above the sum, or extrapolate on the last segment
               lo_in    = prev_ff;
               hi_in    = mem_rd_data;
               seg_in   = idx_ff;
               state_in = S_SCALE;
            end else begin
               prev_in  = mem_rd_data;
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end

         S_SCALE: begin
            base_in = WEIGHT_W'(WEIGHT_W'(seg_m1) * WEIGHT_W'(plws_pkg::GRAMS_PER_POINT));
            if (degenerate) begin
               grams_in = '0;
               fault_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               fault_in = 1'b0;
               state_in = S_DIVIDE;
            end
         end

         S_DIVIDE: begin
            if (div_done) begin
               grams_in = (grams_total > {{(NUM_W+1-WEIGHT_W){1'b0}}, plws_pkg::WEIGHT_MAX}) ?
                          plws_pkg::WEIGHT_MAX : grams_total[WEIGHT_W-1:0];
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_grams_in = grams_ff;
               rsp_sum_in   = sum_ff;
               rsp_iscal_in = iscal_ff;
               rsp_slot_in  = slotout_ff;
               rsp_fault_in = fault_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff       <= sum_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      seg_ff       <= seg_in;
      base_ff      <= base_in;
      grams_ff     <= grams_in;
      fault_ff     <= fault_in;
      iscal_ff     <= iscal_in;
      slotout_ff   <= slotout_in;
      rsp_grams_ff <= rsp_grams_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_iscal_ff <= rsp_iscal_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_weight_grams   = rsp_grams_ff;
   assign rsp_sample_sum     = rsp_sum_ff;
   assign rsp_is_calibration = rsp_iscal_ff;
   assign rsp_stored_slot    = rsp_slot_ff;
   assign rsp_fault          = rsp_fault_ff;

`ifndef NO_ASSERTIONS
   a_div_done_in_divide : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside the divide state");

   a_cal_result_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_iscal_ff) |-> ((rsp_grams_ff == '0) && !rsp_fault_ff))
      else $error("calibration result carries a weight or fault");

   a_fault_zero_weight : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_grams_ff == '0))
      else $error("faulted result carries a weight");

   a_slot_in_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} < POINT_LIMIT)
      else $error("capture slot beyond the table");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < GROUP_LEN)
      else $error("sample count reached the group length");
`endif

endmodule : piecewise_linear_weight_scale

`default_nettype wire

@@ rtl/plws_bp_mem.sv @@
`default_nettype none

// Breakpoint store: one write port, one read port, registered read data.
// Per-entry valid bits make an entry read as zero until it is first written.
module plws_bp_mem #(
   parameter int DEPTH  = plws_pkg::BREAKPOINTS_DEF,
   parameter int ADDR_W = $clog2(plws_pkg::BREAKPOINTS_DEF),
   parameter int DATA_W = plws_pkg::SUM_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] q_ff;
   logic              hit_ff;

   // write the array and fetch the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   // track which entries hold written data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? q_ff : '0;

endmodule : plws_bp_mem

`default_nettype wire

@@ rtl/plws_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. done is high for a single cycle,
// registered together with the last step; quotient holds until the next start.
module plws_div #(
   parameter int NUM_W = plws_pkg::NUM_W,
   parameter int DEN_W = plws_pkg::SUM_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] trial;
   logic             borrow;

   // shift in the next dividend bit and try to subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      trial  = {1'b0, rem_sh} - {2'b00, den_ff};
      borrow = trial[DEN_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = borrow ? rem_sh[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ~borrow};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : plws_div

`default_nettype wire

@@ test/scale_tb_pkg.sv @@
`timescale 1ns / 1ps

package scale_tb_pkg;

   // request beat kinds
   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_POINT  = 1'b1
   } req_func_type;

   // calibrate_mode register values
   typedef enum logic {
      MODE_MEASURE   = 1'b0,
      MODE_CALIBRATE = 1'b1
   } scale_mode_type;

   // register index past the mode register, writes there are dropped
   localparam int CSR_SPARE_INDEX = 1;

endpackage : scale_tb_pkg

@@ test/weighing_checker.sv @@
`timescale 1ns / 1ps

module weighing_checker #(
   parameter int SAMPLES_PER_AVERAGE = plws_pkg::SAMPLES_PER_AVERAGE_DEF,
   parameter int BREAKPOINTS         = plws_pkg::BREAKPOINTS_DEF,
   parameter int ADC_BITS            = plws_pkg::ADC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_func,
   input  logic [plws_pkg::SAMPLE_W-1:0]     req_adc_sample,
   input  logic [plws_pkg::INDEX_W-1:0]      req_point_index,
   input  logic [plws_pkg::SUM_W-1:0]        req_point_value,

   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [plws_pkg::WEIGHT_W-1:0]     rsp_weight_grams,
   input  logic [plws_pkg::SUM_W-1:0]        rsp_sample_sum,
   input  logic                              rsp_is_calibration,
   input  logic [plws_pkg::INDEX_W-1:0]      rsp_stored_slot,
   input  logic                              rsp_fault,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [plws_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [plws_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [plws_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                              csr_pready,

   output int                                error_count,
   output int                                outstanding
);
   import plws_pkg::*;
   import scale_tb_pkg::*;

   localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight_grams;
      logic [SUM_W-1:0]    sample_sum;
      logic                is_calibration;
      logic [INDEX_W-1:0]  stored_slot;
      logic                fault;
   } weighing_type;

   // shadow of the block's state
   logic                calibrating;
   logic [SUM_W-1:0]    running_sum;
   logic [COUNT_W-1:0]  beats_in_group;
   logic [SUM_W-1:0]    breakpoints [BREAKPOINTS];
   logic [INDEX_W-1:0]  next_slot;

   weighing_type        expected_weighings [$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // map a completed sum onto the breakpoint table, flag a degenerate last segment
   function automatic logic [WEIGHT_W-1:0] grams_for_sum(input int unsigned s,
                                                         output logic flt);
      int unsigned       seg;
      int unsigned       i;
      logic              found;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   w;
      flt = 1'b0;
      if (s <= breakpoints[0]) return '0;
      seg   = BREAKPOINTS - 1;
      found = 1'b0;
      for (i = 1; i < BREAKPOINTS; i++) begin
         if (!found && s <= breakpoints[i]) begin
            seg   = i;
            found = 1'b1;
         end
      end
      lo = breakpoints[seg - 1];
      hi = breakpoints[seg];
      if (hi <= lo || s <= lo) begin
         flt = 1'b1;
         return '0;
      end
      w = longint'(seg - 1) * GRAMS_PER_POINT + (s - lo) * GRAMS_PER_POINT / (hi - lo);
      if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      return w[WEIGHT_W-1:0];
   endfunction

   // advance the shadow state by one request beat, queue the weighing it closes
   task automatic take_request(input logic func, input logic [SAMPLE_W-1:0] smp,
                               input logic [INDEX_W-1:0] idx,
                               input logic [SUM_W-1:0] val);
      int unsigned  total;
      weighing_type w;
      logic         flt;
      if (func == FUNC_POINT) begin
         if (idx < BREAKPOINTS) breakpoints[idx] = val;
         return;
      end
      total          = running_sum + (smp & ADC_MASK);
      running_sum    = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
      beats_in_group = beats_in_group + 1'b1;
      if (beats_in_group < SAMPLES_PER_AVERAGE) return;

      w              = '0;
      w.sample_sum   = running_sum;
      running_sum    = '0;
      beats_in_group = '0;
      if (calibrating == MODE_CALIBRATE) begin
         w.is_calibration = 1'b1;
         w.stored_slot    = next_slot;
         if (next_slot < BREAKPOINTS) breakpoints[next_slot] = w.sample_sum;
         next_slot = (next_slot + 1 >= BREAKPOINTS) ? '0 : next_slot + 1'b1;
      end else begin
         w.weight_grams = grams_for_sum(w.sample_sum, flt);
         w.fault        = flt;
      end
      expected_weighings.push_back(w);
   endtask

   // compare one result beat against the oldest queued weighing
   task automatic check_result();
      weighing_type w;
      if (expected_weighings.size() == 0) begin
         $error("unexpected result beat: sample_sum %0d", rsp_sample_sum);
         error_count++;
         return;
      end
      w = expected_weighings.pop_front();
      if (rsp_weight_grams !== w.weight_grams) begin
         $error("weight_grams: expected %0d, got %0d", w.weight_grams, rsp_weight_grams);
         error_count++;
      end
      if (rsp_sample_sum !== w.sample_sum) begin
         $error("sample_sum: expected %0d, got %0d", w.sample_sum, rsp_sample_sum);
         error_count++;
      end
      if (rsp_is_calibration !== w.is_calibration) begin
         $error("is_calibration: expected %0d, got %0d", w.is_calibration,
                rsp_is_calibration);
         error_count++;
      end
      if (rsp_stored_slot !== w.stored_slot) begin
         $error("stored_slot: expected %0d, got %0d", w.stored_slot, rsp_stored_slot);
         error_count++;
      end
      if (rsp_fault !== w.fault) begin
         $error("fault: expected %0d, got %0d", w.fault, rsp_fault);
         error_count++;
      end
   endtask

   // watch all three ports at each edge
   always @(posedge clock) begin
      if (reset) begin
         calibrating    <= MODE_MEASURE;
         running_sum    = '0;
         beats_in_group = '0;
         next_slot      = '0;
         for (int k = 0; k < BREAKPOINTS; k++) breakpoints[k] = '0;
         expected_weighings.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_MODE_INDEX) begin
            if (csr_pwrite) begin
               calibrating <= csr_pwdata[0];
            end else if (csr_prdata !== CSR_DATA_W'(calibrating)) begin
               $error("calibrate_mode: expected %0d, got %0d", calibrating, csr_prdata);
               error_count++;
            end
         end
         if (req_valid && req_ready)
            take_request(req_func, req_adc_sample, req_point_index, req_point_value);
         if (rsp_valid && rsp_ready) check_result();
      end
      outstanding = expected_weighings.size();
   end

endmodule : weighing_checker

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import plws_pkg::*;
   import scale_tb_pkg::*;

   localparam int ADC_MAX         = (1 << ADC_BITS_DEF) - 1;
   localparam int RANDOM_BEATS    = 1500;
   localparam int SETTLE_CYCLES   = 64;
   localparam int HOLDOFF_CYCLES  = 600;
   localparam int WATCHDOG_LIMIT  = 5000;

   logic                    clock;
   logic                    reset           = 1'b1;

   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic                    req_func        = FUNC_SAMPLE;
   logic [SAMPLE_W-1:0]     req_adc_sample  = '0;
   logic [INDEX_W-1:0]      req_point_index = '0;
   logic [SUM_W-1:0]        req_point_value = '0;

   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic [WEIGHT_W-1:0]     rsp_weight_grams;
   logic [SUM_W-1:0]        rsp_sample_sum;
   logic                    rsp_is_calibration;
   logic [INDEX_W-1:0]      rsp_stored_slot;
   logic                    rsp_fault;

   logic                    csr_psel        = 1'b0;
   logic                    csr_penable     = 1'b0;
   logic                    csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr       = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata      = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int                      mismatch_total;
   int                      weighings_due;
   int unsigned             beats_sent      = 0;
   logic                    steady_stretch  = 1'b0;

   piecewise_linear_weight_scale dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_adc_sample     (req_adc_sample),
      .req_point_index    (req_point_index),
      .req_point_value    (req_point_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weight_grams   (rsp_weight_grams),
      .rsp_sample_sum     (rsp_sample_sum),
      .rsp_is_calibration (rsp_is_calibration),
      .rsp_stored_slot    (rsp_stored_slot),
      .rsp_fault          (rsp_fault),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   weighing_checker weight_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_adc_sample     (req_adc_sample),
      .req_point_index    (req_point_index),
      .req_point_value    (req_point_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weight_grams   (rsp_weight_grams),
      .rsp_sample_sum     (rsp_sample_sum),
      .rsp_is_calibration (rsp_is_calibration),
      .rsp_stored_slot    (rsp_stored_slot),
      .rsp_fault          (rsp_fault),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .error_count        (mismatch_total),
      .outstanding        (weighings_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one request beat, hold it until accepted
   task automatic send_beat(input req_func_type f, input int unsigned smp,
                            input int unsigned idx, input int unsigned val);
      while (!steady_stretch && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_adc_sample  <= smp[SAMPLE_W-1:0];
      req_point_index <= idx[INDEX_W-1:0];
      req_point_value <= val[SUM_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!(f == FUNC_POINT && idx[INDEX_W-1:0] >= BREAKPOINTS_DEF)) beats_sent++;
   endtask

   task automatic send_point(input int unsigned idx, input int unsigned val);
      send_beat(FUNC_POINT, $urandom(), idx, val);
   endtask

   // a setup phase, an access phase held until pready, then psel and penable drop
   task automatic csr_access(input logic wr, input int unsigned index,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every weighing to come back, let the block go idle
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (weighings_due != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // rising table with a random base and steps; vary the last segment
   task automatic load_ramp();
      int val;
      int prev;
      val  = $urandom_range(0, 3000);
      prev = 0;
      for (int k = 0; k < BREAKPOINTS_DEF; k++) begin
         send_point(k, val);
         prev = val;
         val  = val + $urandom_range(300, 2500);
      end
      case ($urandom_range(0, 2))
         0: begin
            val = prev - $urandom_range(0, 500);
            send_point(BREAKPOINTS_DEF - 2, prev);
            send_point(BREAKPOINTS_DEF - 1, (val < 0) ? 0 : val);
         end
         1: begin
            val = $urandom_range(5000, 20000);
            send_point(BREAKPOINTS_DEF - 2, val);
            send_point(BREAKPOINTS_DEF - 1, val + $urandom_range(1, 4));
         end
         default: ;
      endcase
   endtask

   // one phase: set the mode, maybe reload the table, stream sample groups
   task automatic run_phase();
      scale_mode_type mode;
      logic [CSR_DATA_W-1:0] data;
      int groups;
      int extra;
      int level;
      int smp;
      int unsigned kind;
      mode = ($urandom_range(0, 99) < 35) ? MODE_CALIBRATE : MODE_MEASURE;
      data = $urandom();
      csr_access(1'b1, CSR_MODE_INDEX, {data[CSR_DATA_W-1:1], mode});
      if ($urandom_range(0, 3) == 0) csr_access(1'b1, CSR_SPARE_INDEX, $urandom());
      csr_access(1'b0, CSR_MODE_INDEX, '0);

      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         load_ramp();
      end else if (kind < 8) begin
         repeat ($urandom_range(4, 12)) send_point($urandom_range(0, 15), $urandom());
      end

      groups = (mode == MODE_CALIBRATE) ? $urandom_range(3, 12) : $urandom_range(2, 6);
      extra  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
      for (int g = 0; g < groups; g++) begin
         if (mode == MODE_CALIBRATE) level = g * 90 + $urandom_range(0, 40);
         else if ($urandom_range(0, 9) == 0) level = 0;
         else if ($urandom_range(0, 9) == 0) level = ADC_MAX;
         else level = $urandom_range(0, ADC_MAX);
         repeat (SAMPLES_PER_AVERAGE_DEF) begin
            steady_stretch = (beats_sent >= 600 && beats_sent < 900);
            if ($urandom_range(0, 19) == 0) send_point($urandom_range(0, 15), $urandom());
            if ($urandom_range(0, 9) == 0) begin
               smp = $urandom_range(0, ADC_MAX);
            end else begin
               smp = level + $urandom_range(0, 60) - 30;
               if (smp < 0) smp = 0;
               if (smp > ADC_MAX) smp = ADC_MAX;
            end
            send_beat(FUNC_SAMPLE, smp, $urandom(), $urandom());
         end
      end
      // leave a partial group so the next mode change lands mid-group
      repeat (extra) send_beat(FUNC_SAMPLE, $urandom(), $urandom(), $urandom());
      drain_and_settle();
   endtask

   // stimulus and verdict
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] data;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      data = $urandom();
      csr_access(1'b1, CSR_MODE_INDEX, {data[CSR_DATA_W-1:1], MODE_MEASURE});
      csr_access(1'b0, CSR_MODE_INDEX, '0);

      // a zero then full-scale samples against the empty table: degenerate last segment
      send_beat(FUNC_SAMPLE, 0, $urandom(), $urandom());
      repeat (SAMPLES_PER_AVERAGE_DEF - 1) send_beat(FUNC_SAMPLE, ADC_MAX, $urandom(), $urandom());
      // out-of-range point writes are dropped, then the table extremes
      send_point(15, 16'h7FFF);
      send_point(BREAKPOINTS_DEF, 0);
      send_point(BREAKPOINTS_DEF - 1, 20460);
      send_point(0, 0);
      drain_and_settle();

      while (beats_sent < RANDOM_BEATS) run_phase();
      steady_stretch = 1'b0;
      drain_and_settle();

      if (mismatch_total == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // result side: random stalls, two long hold-offs to back the block up
   initial begin : rsp_side
      int unsigned results_seen;
      int unsigned hold_left;
      results_seen = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (results_seen == 12 || results_seen == 45) hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_stretch || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // end the run when no beat moves on any port for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule : testbench
